// File: rtl/crc16_reflected_augmented_core_defines.svh
// Assertion macros for the CRC-16 core.
// Needs clk_i and rst_ni in the including module's scope.
`ifndef CRC16_REFLECTED_AUGMENTED_CORE_DEFINES_SVH
`define CRC16_REFLECTED_AUGMENTED_CORE_DEFINES_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define CRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication shorthand: antecedent, then consequent in the following cycle.
`define CRC_ASSERT_NEXT(label, ante, cons, msg) \
  `CRC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: rtl/crc16ra_pkg.sv
// Shared constants, types and helpers for the CRC-16 core.
// No dependencies.
package crc16ra_pkg;

  localparam int unsigned CrcWidth  = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned AddrWidth = 3;

  localparam logic [CrcWidth-1:0] PolyReset = 16'h8005;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

  // word index of each register on the APB port
  typedef enum logic [0:0] {
    RegPoly = 1'b0
  } reg_idx_e;

  function automatic crc_t reverse_crc(crc_t v);
    crc_t r;
    for (int i = 0; i < CrcWidth; i++) begin
      r[i] = v[CrcWidth-1-i];
    end
    return r;
  endfunction

endpackage

// File: rtl/crc16ra_shift8.sv
// Eight bit steps of the reflected CRC division, LSB of the byte first.
// Depends on crc16ra_pkg.
module crc16ra_shift8
  import crc16ra_pkg::*;
(
  input  crc_t  rem_i,
  input  byte_t bits_i,
  input  crc_t  poly_i,
  output crc_t  rem_o
);

  always_comb begin
    crc_t r;
    logic top;
    r = rem_i;
    for (int i = 0; i < ByteWidth; i++) begin
      top = r[CrcWidth-1];
      r   = {r[CrcWidth-2:0], bits_i[i]};
      if (top) begin
        r = r ^ poly_i;
      end
    end
    rem_o = r;
  end

endmodule

// File: rtl/crc16_reflected_augmented_core.sv
// Top level of the CRC-16 core: stream ports, APB register, finishing pipe.
// Depends on crc16ra_pkg, crc16ra_shift8 and the assertion macro header.
//
// Takes one message byte per transfer on s_axis (tlast marks the final byte)
// and sustains one byte per clock while s_axis_tready is high. The running
// remainder absorbs the byte in the cycle it is accepted, through one
// eight-bit unrolled step. A final byte then runs through two more eight-bit
// steps that shift in the sixteen zero bits; the bit-reversed CRC passes
// fin1_q, fin2_q and the output register to m_axis. Non-final bytes give no
// output. Bytes keep flowing while a finished CRC waits; s_axis_tready drops
// only when the first finishing stage is full and cannot advance.
// generator_poly sits at APB address 0 (reset 0x8005, CRC-16/ARC); the user
// must write it only while the core is idle, which the core does not enforce.
`include "crc16_reflected_augmented_core_defines.svh"

module crc16_reflected_augmented_core
  import crc16ra_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // final_byte
  // stream out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [15:0] crc_value
  // APB register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  crc_t poly_q;
  crc_t rem_q, rem_d;
  crc_t absorb;
  crc_t fin1_q, fin2_q, fin2_d, fin3;
  logic v1_q, v2_q, out_v_q;
  crc_t out_q;

  logic in_xfer, out_rdy, v2_rdy, v1_rdy;
  logic cfg_wr;
  reg_idx_e reg_sel;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[AddrWidth-1]);
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_sel == RegPoly);

  always_comb begin
    case (reg_sel)
      RegPoly: prdata = {16'b0, poly_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
    end else if (cfg_wr) begin
      poly_q <= pwdata[CrcWidth-1:0];
    end
  end

  // ---------------- handshakes ----------------
  assign out_rdy       = !out_v_q || m_axis_tready;
  assign v2_rdy        = !v2_q || out_rdy;
  assign v1_rdy        = !v1_q || v2_rdy;
  assign s_axis_tready = v1_rdy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // ---------------- datapath ----------------
  crc16ra_shift8 u_absorb (
    .rem_i  (rem_q),
    .bits_i (s_axis_tdata),
    .poly_i (poly_q),
    .rem_o  (absorb)
  );

  crc16ra_shift8 u_zero_lo (
    .rem_i  (fin1_q),
    .bits_i ('0),
    .poly_i (poly_q),
    .rem_o  (fin2_d)
  );

  crc16ra_shift8 u_zero_hi (
    .rem_i  (fin2_q),
    .bits_i ('0),
    .poly_i (poly_q),
    .rem_o  (fin3)
  );

  assign rem_d = s_axis_tlast ? '0 : absorb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        rem_q <= rem_d;
      end
      if (v1_rdy) begin
        v1_q <= in_xfer && s_axis_tlast;
      end
      if (v2_rdy) begin
        v2_q <= v1_q;
      end
      if (out_rdy) begin
        out_v_q <= v2_q;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast) begin
      fin1_q <= absorb;
    end
    if (v1_q && v2_rdy) begin
      fin2_q <= fin2_d;
    end
    if (v2_q && out_rdy) begin
      out_q <= reverse_crc(fin3);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // ---------------- checks ----------------
  `CRC_ASSERT_NEXT(a_final_clears_rem, in_xfer && s_axis_tlast, rem_q == '0,
                   "remainder not cleared after final byte")
  `CRC_ASSERT_NEXT(a_final_enters_pipe, in_xfer && s_axis_tlast, v1_q,
                   "final byte did not enter finishing stage")
  `CRC_ASSERT(a_stall_only_when_full, !s_axis_tready |-> (v1_q && v2_q && out_v_q),
              "input stalled with room in the finishing pipe")
  `CRC_ASSERT_NEXT(a_result_moves_out, v2_q && out_rdy, m_axis_tvalid,
                   "finished CRC lost before output register")

endmodule
